FILE: design/c2drb_pkg.sv
package c2drb_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 2;
	localparam int NUM_LINES  = 2 * MAX_RADIUS + 1;
	localparam int NUM_KROWS  = 5;
	localparam int COEF_W     = 12;
	localparam int PIX_W      = 16;
	localparam int POS_W      = 10;
	localparam int SIZE_W     = 11;
	localparam int RAD_W      = 2;
	localparam int KROW_W     = 60;
	localparam int SUM_W      = 32;
	localparam int PROD_W     = PIX_W + COEF_W;
	localparam int LINE_W     = 3;
	localparam int TAP_W      = 3;
	localparam int SPOS_W     = POS_W + 2;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KROW0  = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_TAP,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic issue;
		logic result_load;
		logic next_result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_results;
		logic taps_last;
		logic pipe_busy;
		logic out_taken;
		logic last_result;
	} ctrl_status_t;

	// row mod 5: 16 = 1 (mod 5), so nibble sums keep the residue
	function automatic logic [LINE_W-1:0] mod5(input logic [POS_W-1:0] x);
		logic [5:0] s;
		logic [4:0] t;
		s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[9:8]);
		t = 5'(s[3:0]) + 5'(s[5:4]);
		if (t >= 5'd10) t = t - 5'd10;
		if (t >= 5'd5) t = t - 5'd5;
		return t[LINE_W-1:0];
	endfunction

endpackage

FILE: design/c2drb_ctrl.sv
module c2drb_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  c2drb_pkg::ctrl_status_t status,
	output c2drb_pkg::ctrl_cmd_t    cmd
);

	c2drb_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c2drb_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			c2drb_pkg::ST_IDLE: begin
				if (in_valid) state_next = c2drb_pkg::ST_SETUP;
			end
			c2drb_pkg::ST_SETUP: begin
				state_next = status.has_results ? c2drb_pkg::ST_TAP : c2drb_pkg::ST_IDLE;
			end
			c2drb_pkg::ST_TAP: begin
				if (status.taps_last) state_next = c2drb_pkg::ST_DRAIN;
			end
			c2drb_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) state_next = c2drb_pkg::ST_OUT;
			end
			c2drb_pkg::ST_OUT: begin
				if (status.out_taken)
					state_next = status.last_result ? c2drb_pkg::ST_IDLE : c2drb_pkg::ST_TAP;
			end
			default: state_next = c2drb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			c2drb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			c2drb_pkg::ST_SETUP: cmd.setup = 1'b1;
			c2drb_pkg::ST_TAP:   cmd.issue = 1'b1;
			c2drb_pkg::ST_DRAIN: cmd.result_load = !status.pipe_busy;
			c2drb_pkg::ST_OUT:   cmd.next_result = status.out_taken && !status.last_result;
			default: ;
		endcase
	end

endmodule

FILE: design/c2drb_datapath.sv
module c2drb_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [c2drb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [c2drb_pkg::KROW_W-1:0]         cfg_data,
	input  logic signed [c2drb_pkg::PIX_W-1:0]   pixel,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic [c2drb_pkg::POS_W-1:0]          out_row,
	output logic [c2drb_pkg::POS_W-1:0]          out_col,
	output logic signed [c2drb_pkg::SUM_W-1:0]   value,
	output logic                                 last_of_run,
	input  c2drb_pkg::ctrl_cmd_t                 cmd,
	output c2drb_pkg::ctrl_status_t              status
);

	localparam int MEM_DEPTH = c2drb_pkg::NUM_LINES * c2drb_pkg::MAX_WIDTH;
	localparam int ADDR_W = c2drb_pkg::LINE_W + c2drb_pkg::POS_W;

	logic [c2drb_pkg::SIZE_W-1:0] width_q, height_q;
	logic [c2drb_pkg::RAD_W-1:0]  radius_q;
	logic [c2drb_pkg::KROW_W-1:0] krow_q [c2drb_pkg::NUM_KROWS];

	logic [c2drb_pkg::POS_W-1:0] row_cnt_q, col_cnt_q;
	logic [c2drb_pkg::POS_W-1:0] i_q, j_q, wm1_q, hm1_q;
	logic [c2drb_pkg::RAD_W-1:0] rad_q;
	logic [c2drb_pkg::PIX_W-1:0] pix_q;

	logic [c2drb_pkg::POS_W-1:0] r_cur_q, c_cur_q, r_hi_q, c_hi_q, c_lo_q;
	logic [c2drb_pkg::TAP_W-1:0] kr_q, kc_q;

	logic [c2drb_pkg::PIX_W-1:0] mem [MEM_DEPTH];

	logic                               vld_s1, vld_s2;
	logic signed [c2drb_pkg::PIX_W-1:0]  rd_s1;
	logic signed [c2drb_pkg::COEF_W-1:0] coef_s1;
	logic signed [c2drb_pkg::PROD_W-1:0] prod_s2;
	logic signed [c2drb_pkg::SUM_W-1:0]  acc_q;

	logic out_valid_q;
	logic [c2drb_pkg::POS_W-1:0] out_row_q, out_col_q;
	logic signed [c2drb_pkg::SUM_W-1:0] value_q;
	logic last_q;

	// effective sizes from the registers
	logic [c2drb_pkg::SIZE_W-1:0] w_eff, h_eff;
	logic [c2drb_pkg::POS_W-1:0]  wm1, hm1;
	logic [c2drb_pkg::RAD_W-1:0]  rad_eff;

	always_comb begin
		w_eff = (width_q == '0) ? c2drb_pkg::SIZE_W'(1) :
			((width_q > c2drb_pkg::SIZE_W'(c2drb_pkg::MAX_WIDTH)) ?
			c2drb_pkg::SIZE_W'(c2drb_pkg::MAX_WIDTH) : width_q);
		h_eff = (height_q == '0) ? c2drb_pkg::SIZE_W'(1) :
			((height_q > c2drb_pkg::SIZE_W'(c2drb_pkg::MAX_HEIGHT)) ?
			c2drb_pkg::SIZE_W'(c2drb_pkg::MAX_HEIGHT) : height_q);
		wm1 = c2drb_pkg::POS_W'(w_eff - c2drb_pkg::SIZE_W'(1));
		hm1 = c2drb_pkg::POS_W'(h_eff - c2drb_pkg::SIZE_W'(1));
		rad_eff = (radius_q > c2drb_pkg::RAD_W'(c2drb_pkg::MAX_RADIUS)) ?
			c2drb_pkg::RAD_W'(c2drb_pkg::MAX_RADIUS) : radius_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c2drb_pkg::SIZE_W'(c2drb_pkg::MAX_WIDTH);
			height_q <= c2drb_pkg::SIZE_W'(c2drb_pkg::MAX_HEIGHT);
			radius_q <= c2drb_pkg::RAD_W'(1);
			for (int k = 0; k < c2drb_pkg::NUM_KROWS; k++) krow_q[k] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				c2drb_pkg::REG_WIDTH:  width_q  <= cfg_data[c2drb_pkg::SIZE_W-1:0];
				c2drb_pkg::REG_HEIGHT: height_q <= cfg_data[c2drb_pkg::SIZE_W-1:0];
				c2drb_pkg::REG_RADIUS: radius_q <= cfg_data[c2drb_pkg::RAD_W-1:0];
				default: krow_q[3'(cfg_index - c2drb_pkg::REG_KROW0)] <= cfg_data;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			i_q   <= (row_cnt_q > hm1) ? hm1 : row_cnt_q;
			j_q   <= (col_cnt_q > wm1) ? wm1 : col_cnt_q;
			wm1_q <= wm1;
			hm1_q <= hm1;
			rad_q <= rad_eff;
			pix_q <= pixel;
		end
	end

	// result window bounds
	logic signed [c2drb_pkg::SPOS_W-1:0] r_lo, c_lo;
	logic [c2drb_pkg::POS_W-1:0] r_hi, c_hi;
	always_comb begin
		r_lo = $signed({2'b00, i_q}) - $signed(c2drb_pkg::SPOS_W'(rad_q));
		c_lo = $signed({2'b00, j_q}) - $signed(c2drb_pkg::SPOS_W'(rad_q));
		if (i_q == hm1_q) begin
			if (r_lo < 0) r_lo = '0;
			r_hi = i_q;
		end else begin
			r_hi = r_lo[c2drb_pkg::POS_W-1:0];
		end
		if (j_q == wm1_q) begin
			if (c_lo < 0) c_lo = '0;
			c_hi = j_q;
		end else begin
			c_hi = c_lo[c2drb_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
			col_cnt_q <= '0;
		end else if (cmd.setup) begin
			if (j_q == wm1_q) begin
				col_cnt_q <= '0;
				row_cnt_q <= (i_q == hm1_q) ? '0 : i_q + 1'b1;
			end else begin
				col_cnt_q <= j_q + 1'b1;
				row_cnt_q <= i_q;
			end
		end
	end

	// tap sequencing
	logic [c2drb_pkg::TAP_W-1:0] kmax;
	assign kmax = {rad_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			r_cur_q <= r_lo[c2drb_pkg::POS_W-1:0];
			c_cur_q <= c_lo[c2drb_pkg::POS_W-1:0];
			c_lo_q  <= c_lo[c2drb_pkg::POS_W-1:0];
			r_hi_q  <= r_hi;
			c_hi_q  <= c_hi;
			kr_q    <= '0;
			kc_q    <= '0;
		end else if (cmd.next_result) begin
			kr_q <= '0;
			kc_q <= '0;
			if (c_cur_q == c_hi_q) begin
				c_cur_q <= c_lo_q;
				r_cur_q <= r_cur_q + 1'b1;
			end else begin
				c_cur_q <= c_cur_q + 1'b1;
			end
		end else if (cmd.issue) begin
			if (kc_q == kmax) begin
				kc_q <= '0;
				kr_q <= kr_q + 1'b1;
			end else begin
				kc_q <= kc_q + 1'b1;
			end
		end
	end

	// neighbor position, clamped to the image
	logic signed [c2drb_pkg::SPOS_W-1:0] rr_s, cc_s;
	logic [c2drb_pkg::POS_W-1:0] rr, cc;
	always_comb begin
		rr_s = $signed({2'b00, r_cur_q}) + $signed(c2drb_pkg::SPOS_W'(kr_q))
			- $signed(c2drb_pkg::SPOS_W'(rad_q));
		cc_s = $signed({2'b00, c_cur_q}) + $signed(c2drb_pkg::SPOS_W'(kc_q))
			- $signed(c2drb_pkg::SPOS_W'(rad_q));
		if (rr_s < 0) rr = '0;
		else if (rr_s > $signed({2'b00, hm1_q})) rr = hm1_q;
		else rr = rr_s[c2drb_pkg::POS_W-1:0];
		if (cc_s < 0) cc = '0;
		else if (cc_s > $signed({2'b00, wm1_q})) cc = wm1_q;
		else cc = cc_s[c2drb_pkg::POS_W-1:0];
	end

	logic [ADDR_W-1:0] wr_addr, rd_addr;
	assign wr_addr = {c2drb_pkg::mod5(i_q), j_q};
	assign rd_addr = {c2drb_pkg::mod5(rr), cc};

	always_ff @(posedge clk) begin
		if (cmd.setup) mem[wr_addr] <= pix_q;
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		coef_s1 <= krow_q[kr_q][kc_q*c2drb_pkg::COEF_W +: c2drb_pkg::COEF_W];
		prod_s2 <= rd_s1 * coef_s1;
		if (cmd.setup || cmd.next_result) acc_q <= '0;
		else if (vld_s2) acc_q <= acc_q + c2drb_pkg::SUM_W'(prod_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// result register
	logic last_result;
	assign last_result = (r_cur_q == r_hi_q) && (c_cur_q == c_hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			out_row_q <= r_cur_q;
			out_col_q <= c_cur_q;
			value_q   <= acc_q;
			last_q    <= last_result;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign value       = value_q;
	assign last_of_run = last_q;

	always_comb begin
		status.has_results = (r_lo >= 0) && (c_lo >= 0);
		status.taps_last   = (kr_q == kmax) && (kc_q == kmax);
		status.pipe_busy   = vld_s1 || vld_s2;
		status.out_taken   = out_valid_q && !out_stall;
		status.last_result = last_result;
	end

endmodule

FILE: design/conv2d_replicate_border_unit.sv
// channel | signals                        | accepted when
// cfg     | cfg_we, cfg_index, cfg_data    | cfg_we high
// in      | in_valid, in_stall, pixel      | in_valid && !in_stall
// out     | out_valid, out_stall, out_row, | out_valid && !out_stall
//         | out_col, value, last_of_run    |
// A pixel that completes no window passes through setup back to idle.
// Each result takes one line-store read and one multiply-accumulate per
// kernel tap, then a pipeline drain and its output handshake.
// One pixel at a time; in_stall stays high until its last result is taken.
// arst_n resets control and configuration; the line store is not cleared.
module conv2d_replicate_border_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [c2drb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [c2drb_pkg::KROW_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [c2drb_pkg::PIX_W-1:0] pixel,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [c2drb_pkg::POS_W-1:0]        out_row,
	output logic [c2drb_pkg::POS_W-1:0]        out_col,
	output logic signed [c2drb_pkg::SUM_W-1:0] value,
	output logic                               last_of_run
);

	c2drb_pkg::ctrl_cmd_t    cmd;
	c2drb_pkg::ctrl_status_t status;

	c2drb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	c2drb_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (pixel),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_row     (out_row),
		.out_col     (out_col),
		.value       (value),
		.last_of_run (last_of_run),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

FILE: design/c2drb_checker.sv
module c2drb_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [c2drb_pkg::POS_W-1:0]        out_row,
	input logic [c2drb_pkg::POS_W-1:0]        out_col,
	input logic signed [c2drb_pkg::SUM_W-1:0] value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_row) && $stable(out_col) && $stable(value))
		else $error("stalled result changed");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in progress");

	a_no_req_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

endmodule

bind conv2d_replicate_border_unit c2drb_checker u_c2drb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_row   (out_row),
	.out_col   (out_col),
	.value     (value)
);

FILE: verif/conv2d_replicate_border_unit_tb.sv
module conv2d_replicate_border_unit_tb;

	localparam logic [c2drb_pkg::CFG_IDX_W-1:0] REG_KROW1 = c2drb_pkg::REG_KROW0 + 3'd1;
	localparam logic [c2drb_pkg::CFG_IDX_W-1:0] REG_KROW2 = c2drb_pkg::REG_KROW0 + 3'd2;
	localparam logic [c2drb_pkg::CFG_IDX_W-1:0] REG_KROW3 = c2drb_pkg::REG_KROW0 + 3'd3;
	localparam logic [c2drb_pkg::CFG_IDX_W-1:0] REG_KROW4 = c2drb_pkg::REG_KROW0 + 3'd4;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PIXELS = 440;
	localparam int DIR_STEPS     = 30;

	typedef struct {
		logic [c2drb_pkg::POS_W-1:0]        row;
		logic [c2drb_pkg::POS_W-1:0]        col;
		logic signed [c2drb_pkg::SUM_W-1:0] sum;
		logic                               last;
	} conv_result_t;

	typedef enum logic {STEP_REG, STEP_PIXEL} step_kind_t;

	typedef struct {
		step_kind_t                         kind;
		logic [c2drb_pkg::CFG_IDX_W-1:0]    idx;
		logic [c2drb_pkg::KROW_W-1:0]       data;
		bit                                 typed;
		logic signed [c2drb_pkg::SUM_W-1:0] sum;
	} dir_step_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [c2drb_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [c2drb_pkg::KROW_W-1:0]       cfg_data;
	logic                               in_valid;
	logic                               in_stall;
	logic signed [c2drb_pkg::PIX_W-1:0] pixel;
	logic                               out_valid;
	logic                               out_stall;
	logic [c2drb_pkg::POS_W-1:0]        out_row;
	logic [c2drb_pkg::POS_W-1:0]        out_col;
	logic signed [c2drb_pkg::SUM_W-1:0] value;
	logic                               last_of_run;

	conv2d_replicate_border_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
		.out_col(out_col), .value(value), .last_of_run(last_of_run)
	);

	// shadow of the block's configuration and image state
	logic [c2drb_pkg::SIZE_W-1:0] img_w_reg;
	logic [c2drb_pkg::SIZE_W-1:0] img_h_reg;
	logic [c2drb_pkg::RAD_W-1:0]  radius_reg;
	logic [c2drb_pkg::KROW_W-1:0] kernel_rows [c2drb_pkg::NUM_KROWS];
	logic [c2drb_pkg::PIX_W-1:0]  img_lines [c2drb_pkg::NUM_LINES][c2drb_pkg::MAX_WIDTH];
	int                 row_pos;
	int                 col_pos;

	conv_result_t       pending_results [$];
	int                 n_errors;
	int                 n_taken;
	int                 burst_left;
	int                 random_pixels;

	dir_step_t dir_steps [DIR_STEPS] = '{
		'{STEP_REG,   c2drb_pkg::REG_WIDTH,  60'd1, 0, 0},
		'{STEP_REG,   c2drb_pkg::REG_HEIGHT, 60'd1, 0, 0},
		'{STEP_REG,   c2drb_pkg::REG_RADIUS, 60'd0, 0, 0},
		'{STEP_REG,   c2drb_pkg::REG_KROW0,  60'h001, 0, 0},
		'{STEP_REG,   REG_KROW1,  60'h123456789ABCDEF, 0, 0},
		'{STEP_REG,   REG_KROW2,  60'hFFFFFFFFFFFFFFF, 0, 0},
		'{STEP_REG,   REG_KROW3,  60'h7FF7FF7FF7FF7FF, 0, 0},
		'{STEP_REG,   REG_KROW4,  60'h800800800800800, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h7FFF, 1, 32767},
		'{STEP_PIXEL, 3'd0, 60'h8000, 1, -32768},
		'{STEP_REG,   c2drb_pkg::REG_KROW0,  60'h800, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h8000, 1, 67108864},
		'{STEP_PIXEL, 3'd0, 60'h7FFF, 1, -67106816},
		// radius above the maximum, width of zero
		'{STEP_REG,   c2drb_pkg::REG_RADIUS, 60'd3, 0, 0},
		'{STEP_REG,   c2drb_pkg::REG_WIDTH,  60'd0, 0, 0},
		'{STEP_REG,   c2drb_pkg::REG_HEIGHT, 60'd3, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h7FFF, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h8000, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h0001, 0, 0},
		'{STEP_REG,   c2drb_pkg::REG_WIDTH,  60'd3, 0, 0},
		'{STEP_REG,   c2drb_pkg::REG_RADIUS, 60'd2, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h7FFF, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h8000, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h1234, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'hFFFF, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h0000, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h5A5A, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'hA5A5, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h7FFF, 0, 0},
		'{STEP_PIXEL, 3'd0, 60'h8001, 0, 0}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 4000000);
		$display("conv2d_replicate_border_unit_tb: FAIL");
		$finish;
	end

	function automatic int eff_width();
		return (img_w_reg == 0) ? 1 : ((img_w_reg > c2drb_pkg::MAX_WIDTH) ?
			c2drb_pkg::MAX_WIDTH : int'(img_w_reg));
	endfunction

	function automatic int eff_height();
		return (img_h_reg == 0) ? 1 : ((img_h_reg > c2drb_pkg::MAX_HEIGHT) ?
			c2drb_pkg::MAX_HEIGHT : int'(img_h_reg));
	endfunction

	function automatic longint window_sum(int r, int c, int rad, int w, int h);
		longint acc;
		int rr;
		int cc;
		logic signed [c2drb_pkg::COEF_W-1:0] coef;
		logic signed [c2drb_pkg::PIX_W-1:0]  px;
		acc = 0;
		for (int kr = 0; kr <= 2 * rad; kr++) begin
			rr = r + kr - rad;
			if (rr < 0) rr = 0;
			if (rr > h - 1) rr = h - 1;
			for (int kc = 0; kc <= 2 * rad; kc++) begin
				cc = c + kc - rad;
				if (cc < 0) cc = 0;
				if (cc > w - 1) cc = w - 1;
				coef = kernel_rows[kr][c2drb_pkg::COEF_W*kc +: c2drb_pkg::COEF_W];
				px = img_lines[rr % c2drb_pkg::NUM_LINES][cc];
				acc += longint'(px) * longint'(coef);
			end
		end
		return acc;
	endfunction

	// store the pixel, queue every window it completes, advance the position
	task automatic convolve_pixel(input logic [c2drb_pkg::PIX_W-1:0] p);
		int w, h, rad, i, j, rlo, rhi, clo, chi;
		conv_result_t res;
		w = eff_width();
		h = eff_height();
		rad = (radius_reg > c2drb_pkg::MAX_RADIUS) ? c2drb_pkg::MAX_RADIUS : int'(radius_reg);
		i = (row_pos > h - 1) ? h - 1 : row_pos;
		j = (col_pos > w - 1) ? w - 1 : col_pos;
		img_lines[i % c2drb_pkg::NUM_LINES][j] = p;
		rlo = i - rad;
		rhi = rlo;
		if (i == h - 1) begin
			if (rlo < 0) rlo = 0;
			rhi = i;
		end
		clo = j - rad;
		chi = clo;
		if (j == w - 1) begin
			if (clo < 0) clo = 0;
			chi = j;
		end
		if (rlo >= 0 && clo >= 0) begin
			for (int r = rlo; r <= rhi; r++) begin
				for (int c = clo; c <= chi; c++) begin
					res.row = r[c2drb_pkg::POS_W-1:0];
					res.col = c[c2drb_pkg::POS_W-1:0];
					res.sum = c2drb_pkg::SUM_W'(window_sum(r, c, rad, w, h));
					res.last = (r == rhi && c == chi);
					pending_results = {pending_results, res};
				end
			end
		end
		if (j == w - 1) begin
			col_pos = 0;
			row_pos = (i == h - 1) ? 0 : i + 1;
		end else begin
			col_pos = j + 1;
			row_pos = i;
		end
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic set_reg(input logic [c2drb_pkg::CFG_IDX_W-1:0] idx,
			input logic [c2drb_pkg::KROW_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			c2drb_pkg::REG_WIDTH:  img_w_reg = data[c2drb_pkg::SIZE_W-1:0];
			c2drb_pkg::REG_HEIGHT: img_h_reg = data[c2drb_pkg::SIZE_W-1:0];
			c2drb_pkg::REG_RADIUS: radius_reg = data[c2drb_pkg::RAD_W-1:0];
			default:    kernel_rows[idx - c2drb_pkg::REG_KROW0] = data;
		endcase
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves in_valid high so the next request can follow back to back
	task automatic send_pixel(input logic [c2drb_pkg::PIX_W-1:0] p, input bit typed,
			input logic signed [c2drb_pkg::SUM_W-1:0] typed_sum);
		int gap;
		int before_n;
		conv_result_t res;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (in_stall);
		before_n = pending_results.size();
		convolve_pixel(p);
		if (typed) begin
			while (pending_results.size() > before_n) void'(pending_results.pop_back());
			res.row = '0;
			res.col = '0;
			res.sum = typed_sum;
			res.last = 1'b1;
			pending_results = {pending_results, res};
		end
	endtask

	function automatic logic [c2drb_pkg::PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return c2drb_pkg::PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [c2drb_pkg::KROW_W-1:0] rand_krow();
		return c2drb_pkg::KROW_W'({$urandom, $urandom});
	endfunction

	task automatic run_image(input logic [c2drb_pkg::SIZE_W-1:0] w,
			input logic [c2drb_pkg::SIZE_W-1:0] h,
			input logic [c2drb_pkg::RAD_W-1:0] rad, input bit count_it);
		int n;
		quiesce();
		set_reg(c2drb_pkg::REG_WIDTH, c2drb_pkg::KROW_W'(w));
		set_reg(c2drb_pkg::REG_HEIGHT, c2drb_pkg::KROW_W'(h));
		set_reg(c2drb_pkg::REG_RADIUS, c2drb_pkg::KROW_W'(rad));
		set_reg(c2drb_pkg::REG_KROW0, rand_krow());
		set_reg(REG_KROW1, rand_krow());
		set_reg(REG_KROW2, ($urandom_range(0, 3) == 0) ? 60'hFFFFFFFFFFFFFFF
			: rand_krow());
		set_reg(REG_KROW3, ($urandom_range(0, 3) == 0) ? 60'h800800800800800
			: rand_krow());
		set_reg(REG_KROW4, rand_krow());
		cfg_we <= 1'b0;
		n = eff_width() * eff_height();
		for (int k = 0; k < n; k++) begin
			send_pixel(rand_pixel(), 0, 0);
			if (count_it) random_pixels++;
		end
	endtask

	// receiver: stall pattern of its own, plus one long hold-off
	initial begin
		int hold;
		int mode;
		int mode_left;
		bit held;
		hold = 0;
		mode = 0;
		mode_left = 0;
		held = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (!held && n_taken >= 20) begin
				held = 1;
				hold = 400;
				out_stall <= 1'b1;
			end else begin
				if (mode_left <= 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(30, 200);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 5) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		conv_result_t res;
		if (arst_n && out_valid && !out_stall) begin
			n_taken++;
			if (pending_results.size() == 0) begin
				$error("unexpected result row %0d col %0d value %0d", out_row, out_col, value);
				n_errors++;
			end else begin
				res = pending_results.pop_front();
				if (out_row !== res.row) begin
					$error("out_row: expected %0d, got %0d", res.row, out_row);
					n_errors++;
				end
				if (out_col !== res.col) begin
					$error("out_col: expected %0d, got %0d", res.col, out_col);
					n_errors++;
				end
				if (value !== res.sum) begin
					$error("value: expected %0d, got %0d", res.sum, value);
					n_errors++;
				end
				if (last_of_run !== res.last) begin
					$error("last_of_run: expected %0d, got %0d", res.last, last_of_run);
					n_errors++;
				end
			end
		end
	end

	initial begin
		bit cfg_open;
		n_errors = 0;
		n_taken = 0;
		burst_left = 0;
		random_pixels = 0;
		row_pos = 0;
		col_pos = 0;
		img_w_reg = 11'd1024;
		img_h_reg = 11'd1024;
		radius_reg = 2'd1;
		for (int k = 0; k < c2drb_pkg::NUM_KROWS; k++) kernel_rows[k] = '0;
		cfg_open = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		pixel <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int s = 0; s < DIR_STEPS; s++) begin
			if (dir_steps[s].kind == STEP_REG) begin
				if (!cfg_open) quiesce();
				cfg_open = 1;
				set_reg(dir_steps[s].idx, dir_steps[s].data);
			end else begin
				if (cfg_open) cfg_we <= 1'b0;
				cfg_open = 0;
				send_pixel(dir_steps[s].data[c2drb_pkg::PIX_W-1:0], dir_steps[s].typed,
					dir_steps[s].sum);
			end
		end

		// size extremes: height of zero, width of zero with radius past the maximum
		run_image(11'd12, 11'd0, 2'd2, 1);
		run_image(11'd0, 11'd6, 2'd3, 1);
		while (random_pixels < RANDOM_PIXELS)
			run_image(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)),
				2'($urandom_range(0, 3)), 1);

		quiesce();
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("conv2d_replicate_border_unit_tb: PASS");
		end else begin
			$display("conv2d_replicate_border_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
